// ===== rtl/tsne_adaptive_gain_momentum_update_macros.svh =====
// assertion macros for the tsne adaptive gain momentum update block
// depends on nothing; included by the top level only
`ifndef TSNE_ADAPTIVE_GAIN_MOMENTUM_UPDATE_MACROS_SVH
`define TSNE_ADAPTIVE_GAIN_MOMENTUM_UPDATE_MACROS_SVH

`ifndef SYNTHESIS

`define TAGM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tagm assertion failed");

`define TAGM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tagm assertion failed");

`else

`define TAGM_ASSERT_SAME(lbl, clk, rst_n, ante, cons)

`define TAGM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/tagm_pkg.sv =====
// shared widths, constants and register codes of the adaptive gain momentum update
// no dependencies
package tagm_pkg;

    localparam int IDX_W     = 12;
    localparam int COORD_W   = 32;
    localparam int FORCE_W   = 32;
    localparam int Z_W       = 32;
    localparam int ITER_W    = 16;
    localparam int VEL_W     = 24;
    localparam int GAIN_W    = 16;
    localparam int LR_W      = 10;
    localparam int MOM_W     = 8;
    localparam int VLIM_W    = 23;
    localparam int CFG_W     = 23;
    localparam int CFG_IDX_W = 3;

    localparam int Z_SHIFT    = 16;
    localparam int DIV_W      = FORCE_W + Z_SHIFT;
    localparam int DIV_STAGES = DIV_W;
    localparam int GAIN_FRAC  = 12;

    localparam logic [GAIN_W-1:0] GAIN_ONE = 16'd4096;
    localparam logic [GAIN_W-1:0] GAIN_ADD = 16'd819;
    localparam logic [11:0]       GAIN_MUL = 12'd3277;
    localparam logic [GAIN_W-1:0] GAIN_MIN = 16'd41;
    localparam logic [GAIN_W-1:0] GAIN_MAX = 16'd40960;

    localparam logic [LR_W-1:0]   LR_RST    = 10'd200;
    localparam logic [ITER_W-1:0] SWITCH_RST = 16'd250;
    localparam logic [MOM_W-1:0]  EARLY_RST = 8'd128;
    localparam logic [MOM_W-1:0]  LATE_RST  = 8'd205;
    localparam logic [VLIM_W-1:0] VLIM_RST  = 23'd5242880;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEARNING_RATE    = 3'd0,
        REG_SWITCH_ITERATION = 3'd1,
        REG_EARLY_MOMENTUM   = 3'd2,
        REG_LATE_MOMENTUM    = 3'd3,
        REG_VELOCITY_LIMIT   = 3'd4
    } t_cfg_reg;

endpackage

// ===== rtl/tagm_in_if.sv =====
// input channel: one coordinate element per transaction
// depends on tagm_pkg
interface tagm_in_if;
    logic                                valid;
    logic                                ready;
    logic [tagm_pkg::IDX_W-1:0]          element_index;
    logic signed [tagm_pkg::COORD_W-1:0] coordinate;
    logic signed [tagm_pkg::FORCE_W-1:0] attract_force;
    logic signed [tagm_pkg::FORCE_W-1:0] repel_force;
    logic [tagm_pkg::Z_W-1:0]            normalizer;
    logic [tagm_pkg::ITER_W-1:0]         iteration;

    modport source (
        output valid, element_index, coordinate, attract_force, repel_force,
               normalizer, iteration,
        input  ready
    );
    modport sink (
        input  valid, element_index, coordinate, attract_force, repel_force,
               normalizer, iteration,
        output ready
    );
endinterface

// ===== rtl/tagm_out_if.sv =====
// output channel: updated coordinate, velocity and gain per transaction
// depends on tagm_pkg
interface tagm_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [tagm_pkg::COORD_W-1:0] new_coordinate;
    logic signed [tagm_pkg::VEL_W-1:0]   new_velocity;
    logic [tagm_pkg::GAIN_W-1:0]         new_gain;

    modport source (
        output valid, new_coordinate, new_velocity, new_gain,
        input  ready
    );
    modport sink (
        input  valid, new_coordinate, new_velocity, new_gain,
        output ready
    );
endinterface

// ===== rtl/tsne_adaptive_gain_momentum_update.sv =====
// t-sne gradient step with per-element adaptive gain and momentum, fixed point
// depends on tagm_pkg, tagm_in_if, tagm_out_if and the assertion macro header
//
// One transaction in gives one transaction out. The block takes one element per
// clock unless an index hazard, the clearing pass or a full skid register holds
// the input; the 48-stage bit-per-stage divider forms repel_force / normalizer.
// Velocity and gain live in one MAX_ELEMENTS-deep memory that is read, updated
// and written back; an element whose index matches one of the three elements
// ahead of it in the update stages waits there, so same-index elements closer
// than four transactions stall the input. After reset a clearing pass over all
// MAX_ELEMENTS addresses loads the memory with zero velocity and unit gain; no
// transaction is taken meanwhile, configuration writes are. The output has a
// skid register, so input stays open while one result waits.
`include "tsne_adaptive_gain_momentum_update_macros.svh"

module tsne_adaptive_gain_momentum_update #(
    parameter int MAX_ELEMENTS = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    tagm_in_if.sink                        i_in,
    tagm_out_if.source                     o_out,
    input  logic                           i_cfg_we,
    input  logic [tagm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tagm_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int AW     = $clog2(MAX_ELEMENTS);
    localparam int IDX_W  = tagm_pkg::IDX_W;
    localparam int DIV_W  = tagm_pkg::DIV_W;
    localparam int NST    = tagm_pkg::DIV_STAGES;
    localparam int VEL_W  = tagm_pkg::VEL_W;
    localparam int GAIN_W = tagm_pkg::GAIN_W;
    localparam int MEM_W  = VEL_W + GAIN_W;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic signed [31:0] coord;
        logic signed [31:0] attract;
        logic [15:0]       iter;
        logic              neg;
        logic [31:0]       dsor;
        logic [31:0]       rem;
        logic [DIV_W-1:0]  work;
    } t_div;

    typedef struct packed {
        logic [AW-1:0]      addr;
        logic signed [31:0] coord;
        logic signed [31:0] grad;
        logic [15:0]        iter;
    } t_s01;

    typedef struct packed {
        logic [AW-1:0]      addr;
        logic signed [31:0] coord;
        logic signed [31:0] grad;
        logic [GAIN_W-1:0]  gain;
        logic signed [32:0] momv;
    } t_s2;

    typedef struct packed {
        logic [AW-1:0]      addr;
        logic signed [31:0] coord;
        logic signed [31:0] grad;
        logic [GAIN_W-1:0]  gain;
        logic signed [32:0] momv;
        logic [25:0]        p1;
    } t_s3;

    typedef struct packed {
        logic [AW-1:0]      addr;
        logic signed [31:0] coord;
        logic [GAIN_W-1:0]  gain;
        logic signed [32:0] momv;
        logic signed [57:0] p2;
    } t_s4;

    typedef struct packed {
        logic [AW-1:0]           addr;
        logic signed [31:0]      coord;
        logic signed [VEL_W-1:0] vnew;
        logic [GAIN_W-1:0]       gain;
    } t_s5;

    typedef struct packed {
        logic signed [31:0]      coord;
        logic signed [VEL_W-1:0] vel;
        logic [GAIN_W-1:0]       gain;
    } t_res;

    // configuration
    logic [tagm_pkg::LR_W-1:0]   r_lr;
    logic [tagm_pkg::ITER_W-1:0] r_switch;
    logic [tagm_pkg::MOM_W-1:0]  r_early;
    logic [tagm_pkg::MOM_W-1:0]  r_late;
    logic [tagm_pkg::VLIM_W-1:0] r_vlim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr     <= tagm_pkg::LR_RST;
            r_switch <= tagm_pkg::SWITCH_RST;
            r_early  <= tagm_pkg::EARLY_RST;
            r_late   <= tagm_pkg::LATE_RST;
            r_vlim   <= tagm_pkg::VLIM_RST;
        end else if (i_cfg_we) begin
            unique case (tagm_pkg::t_cfg_reg'(i_cfg_index))
                tagm_pkg::REG_LEARNING_RATE:    r_lr     <= i_cfg_data[tagm_pkg::LR_W-1:0];
                tagm_pkg::REG_SWITCH_ITERATION: r_switch <= i_cfg_data[tagm_pkg::ITER_W-1:0];
                tagm_pkg::REG_EARLY_MOMENTUM:   r_early  <= i_cfg_data[tagm_pkg::MOM_W-1:0];
                tagm_pkg::REG_LATE_MOMENTUM:    r_late   <= i_cfg_data[tagm_pkg::MOM_W-1:0];
                tagm_pkg::REG_VELOCITY_LIMIT:   r_vlim   <= i_cfg_data[tagm_pkg::VLIM_W-1:0];
                default: ;
            endcase
        end
    end

    // clearing pass
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == AW'(MAX_ELEMENTS - 1)) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    // pipeline control
    logic r_skv;
    logic r_ov;
    logic adv;
    logic hazard;
    logic front_adv;
    logic in_acc;

    logic r_s0_v, r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v;
    t_s01 r_s0, r_s1;
    t_s2  r_s2;
    t_s3  r_s3;
    t_s4  r_s4;
    t_s5  r_s5;
    t_s5  r_wb;
    logic r_wb_v;

    assign adv    = !r_skv;
    assign hazard = r_s0_v && ((r_s1_v && r_s1.addr == r_s0.addr)
                            || (r_s2_v && r_s2.addr == r_s0.addr)
                            || (r_s3_v && r_s3.addr == r_s0.addr));
    assign front_adv  = adv && !hazard;
    assign i_in.ready = front_adv && !r_clr_busy;
    assign in_acc     = i_in.valid && i_in.ready;

    // divider front end
    t_div r_dv     [0:NST];
    logic r_dv_vld [0:NST];

    logic        rep_neg;
    logic [31:0] rep_u;
    logic [31:0] rep_abs;

    assign rep_neg = i_in.repel_force[31];
    assign rep_u   = i_in.repel_force;
    assign rep_abs = rep_neg ? (~rep_u + 32'd1) : rep_u;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (front_adv) begin
            r_dv_vld[0] <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (front_adv) begin
            r_dv[0].idx     <= i_in.element_index;
            r_dv[0].coord   <= i_in.coordinate;
            r_dv[0].attract <= i_in.attract_force;
            r_dv[0].iter    <= i_in.iteration;
            r_dv[0].neg     <= rep_neg;
            r_dv[0].dsor    <= (i_in.normalizer == '0) ? 32'd1 : i_in.normalizer;
            r_dv[0].rem     <= '0;
            r_dv[0].work    <= {rep_abs, {tagm_pkg::Z_SHIFT{1'b0}}};
        end
    end

    // restoring divider, one quotient bit per stage; index modulo rides along
    for (genvar s = 0; s < NST; s++) begin : g_div
        logic [32:0]      trial;
        logic [32:0]      diff;
        logic             take;
        logic [31:0]      n_rem;
        logic [DIV_W-1:0] n_work;
        logic [IDX_W-1:0] n_idx;

        always_comb begin
            trial  = {r_dv[s].rem, r_dv[s].work[DIV_W-1]};
            diff   = trial - {1'b0, r_dv[s].dsor};
            take   = trial >= {1'b0, r_dv[s].dsor};
            n_rem  = take ? diff[31:0] : trial[31:0];
            n_work = {r_dv[s].work[DIV_W-2:0], take};
        end

        if (s < IDX_W) begin : g_red
            localparam longint SUBL = longint'(MAX_ELEMENTS) << (IDX_W - 1 - s);
            if (SUBL < (longint'(1) << IDX_W)) begin : g_sub
                localparam logic [IDX_W-1:0] SUBV = IDX_W'(SUBL);
                assign n_idx = (r_dv[s].idx >= SUBV) ? (r_dv[s].idx - SUBV) : r_dv[s].idx;
            end else begin : g_keep
                assign n_idx = r_dv[s].idx;
            end
        end else begin : g_pass
            assign n_idx = r_dv[s].idx;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[s+1] <= 1'b0;
            end else if (front_adv) begin
                r_dv_vld[s+1] <= r_dv_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (front_adv) begin
                r_dv[s+1].idx     <= n_idx;
                r_dv[s+1].coord   <= r_dv[s].coord;
                r_dv[s+1].attract <= r_dv[s].attract;
                r_dv[s+1].iter    <= r_dv[s].iter;
                r_dv[s+1].neg     <= r_dv[s].neg;
                r_dv[s+1].dsor    <= r_dv[s].dsor;
                r_dv[s+1].rem     <= n_rem;
                r_dv[s+1].work    <= n_work;
            end
        end
    end

    // gradient
    localparam logic signed [49:0] GRAD_MAX = 50'sd2147483647;
    localparam logic signed [49:0] GRAD_MIN = -50'sd2147483648;

    logic signed [49:0] q_mag;
    logic signed [49:0] q_s;
    logic signed [49:0] g_diff;
    logic signed [31:0] grad;

    always_comb begin
        q_mag  = $signed({2'b00, r_dv[NST].work});
        q_s    = r_dv[NST].neg ? -q_mag : q_mag;
        g_diff = 50'(r_dv[NST].attract) - q_s;
        if (g_diff > GRAD_MAX) begin
            grad = 32'(GRAD_MAX);
        end else if (g_diff < GRAD_MIN) begin
            grad = 32'(GRAD_MIN);
        end else begin
            grad = g_diff[31:0];
        end
    end

    // state memory, read first
    logic [MEM_W-1:0] mem [0:MAX_ELEMENTS-1];
    logic [MEM_W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem[r_clr_addr] <= {{VEL_W{1'b0}}, tagm_pkg::GAIN_ONE};
        end else if (adv && r_s5_v) begin
            mem[r_s5.addr] <= {r_s5.vnew, r_s5.gain};
        end
        if (adv) begin
            r_rd <= mem[r_s0.addr];
        end
    end

    // gain update and momentum term
    logic signed [VEL_W-1:0] v_old;
    logic [GAIN_W-1:0]       g_old;
    logic                    differ;
    logic [GAIN_W:0]         g_pre;
    logic [27:0]             g_prod;
    logic [GAIN_W-1:0]       g_new;
    logic [7:0]              mom;
    logic signed [32:0]      momv;

    always_comb begin
        if (r_s5_v && r_s5.addr == r_s1.addr) begin
            v_old = r_s5.vnew;
            g_old = r_s5.gain;
        end else if (r_wb_v && r_wb.addr == r_s1.addr) begin
            v_old = r_wb.vnew;
            g_old = r_wb.gain;
        end else begin
            v_old = r_rd[MEM_W-1:GAIN_W];
            g_old = r_rd[GAIN_W-1:0];
        end
        differ = ((r_s1.grad == '0) != (v_old == '0)) || (r_s1.grad[31] != v_old[VEL_W-1]);
        g_prod = g_old * tagm_pkg::GAIN_MUL;
        g_pre  = differ ? ({1'b0, g_old} + {1'b0, tagm_pkg::GAIN_ADD})
                        : {1'b0, g_prod[tagm_pkg::GAIN_FRAC +: GAIN_W]};
        if (g_pre < {1'b0, tagm_pkg::GAIN_MIN}) begin
            g_new = tagm_pkg::GAIN_MIN;
        end else if (g_pre > {1'b0, tagm_pkg::GAIN_MAX}) begin
            g_new = tagm_pkg::GAIN_MAX;
        end else begin
            g_new = g_pre[GAIN_W-1:0];
        end
        mom  = (r_s1.iter < r_switch) ? r_early : r_late;
        momv = $signed({1'b0, mom}) * v_old;
    end

    // velocity
    logic [25:0]             p1;
    logic signed [57:0]      p2;
    logic signed [59:0]      acc;
    logic signed [47:0]      vsh;
    logic signed [47:0]      vlim;
    logic signed [VEL_W-1:0] vnew;

    always_comb begin
        p1   = r_lr * r_s2.gain;
        p2   = $signed({1'b0, r_s3.p1}) * r_s3.grad;
        acc  = (60'(r_s4.momv) <<< 4) - 60'(r_s4.p2);
        vsh  = acc[59:12];
        vlim = $signed({25'd0, r_vlim});
        if (vsh > vlim) begin
            vnew = vlim[VEL_W-1:0];
        end else if (vsh < -vlim) begin
            vnew = 24'(-vlim);
        end else begin
            vnew = vsh[VEL_W-1:0];
        end
    end

    // new coordinate
    logic signed [32:0] csum;
    t_res               res;

    always_comb begin
        csum = 33'(r_s5.coord) + 33'(r_s5.vnew);
        if (csum[32] != csum[31]) begin
            res.coord = csum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            res.coord = csum[31:0];
        end
        res.vel  = r_s5.vnew;
        res.gain = r_s5.gain;
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
            r_wb_v <= 1'b0;
        end else if (adv) begin
            if (front_adv) begin
                r_s0_v <= r_dv_vld[NST];
            end
            r_s1_v <= r_s0_v && !hazard;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
            r_wb_v <= r_s5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (front_adv) begin
            r_s0.addr  <= AW'(r_dv[NST].idx);
            r_s0.coord <= r_dv[NST].coord;
            r_s0.grad  <= grad;
            r_s0.iter  <= r_dv[NST].iter;
            r_s1       <= r_s0;
        end
        if (adv) begin
            r_s2.addr  <= r_s1.addr;
            r_s2.coord <= r_s1.coord;
            r_s2.grad  <= r_s1.grad;
            r_s2.gain  <= g_new;
            r_s2.momv  <= momv;

            r_s3.addr  <= r_s2.addr;
            r_s3.coord <= r_s2.coord;
            r_s3.grad  <= r_s2.grad;
            r_s3.gain  <= r_s2.gain;
            r_s3.momv  <= r_s2.momv;
            r_s3.p1    <= p1;

            r_s4.addr  <= r_s3.addr;
            r_s4.coord <= r_s3.coord;
            r_s4.gain  <= r_s3.gain;
            r_s4.momv  <= r_s3.momv;
            r_s4.p2    <= p2;

            r_s5.addr  <= r_s4.addr;
            r_s5.coord <= r_s4.coord;
            r_s5.vnew  <= vnew;
            r_s5.gain  <= r_s4.gain;

            r_wb       <= r_s5;
        end
    end

    // output register with skid
    t_res r_out;
    t_res r_sk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_skv <= 1'b0;
        end else if (adv) begin
            if (r_s5_v) begin
                if (!r_ov || o_out.ready) begin
                    r_ov <= 1'b1;
                end else begin
                    r_skv <= 1'b1;
                end
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end else if (o_out.ready) begin
            r_skv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_s5_v) begin
                if (!r_ov || o_out.ready) begin
                    r_out <= res;
                end else begin
                    r_sk <= res;
                end
            end
        end else if (o_out.ready) begin
            r_out <= r_sk;
        end
    end

    assign o_out.valid          = r_ov;
    assign o_out.new_coordinate = r_out.coord;
    assign o_out.new_velocity   = r_out.vel;
    assign o_out.new_gain       = r_out.gain;

    // checks
    `TAGM_ASSERT_SAME(a_no_raw_overlap, i_clk, i_rst_n, r_s1_v, !((r_s2_v && r_s2.addr == r_s1.addr) || (r_s3_v && r_s3.addr == r_s1.addr) || (r_s4_v && r_s4.addr == r_s1.addr)))
    `TAGM_ASSERT_SAME(a_gain_range, i_clk, i_rst_n, r_s2_v, (r_s2.gain >= tagm_pkg::GAIN_MIN) && (r_s2.gain <= tagm_pkg::GAIN_MAX))
    `TAGM_ASSERT_SAME(a_skid_behind_out, i_clk, i_rst_n, r_skv, r_ov)
    `TAGM_ASSERT_NEXT(a_clear_no_entry, i_clk, i_rst_n, r_clr_busy, !r_dv_vld[0] && !r_s5_v)

endmodule
